// File: design/processor_mask_ownership_unit_macros.svh
// ----------------------------------------------------------------------------
// processor_mask_ownership_unit_macros
// Assertion shorthands for the processor mask ownership unit checkers.
// ----------------------------------------------------------------------------
`ifndef PROCESSOR_MASK_OWNERSHIP_UNIT_MACROS_SVH
`define PROCESSOR_MASK_OWNERSHIP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PMOU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PMOU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/pmou_pkg.sv
// ----------------------------------------------------------------------------
// pmou_pkg
// Shared constants, microcode ROM and mask helpers for the ownership unit.
// ----------------------------------------------------------------------------
package pmou_pkg;

   localparam int PROC_COUNT = 64;
   localparam int TASK_COUNT = 64;
   localparam int MASK_W     = 64;

   localparam logic [MASK_W-1:0] PROC_MASK =
      (PROC_COUNT >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << PROC_COUNT) - 64'd1);
   localparam logic [MASK_W-1:0] TASK_BITS =
      (TASK_COUNT >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << TASK_COUNT) - 64'd1);

   localparam logic signed [6:0] NO_INDEX   = 7'sh7F;
   localparam logic [6:0]        PERM_RESET = 7'h7F;

   // request commands
   typedef enum logic [2:0] {
      CMD_PUSH    = 3'd0,
      CMD_POP     = 3'd1,
      CMD_GIVE    = 3'd2,
      CMD_GRANT   = 3'd3,
      CMD_WAIT    = 3'd4,
      CMD_ACQUIRE = 3'd5,
      CMD_READ    = 3'd6,
      CMD_BAD     = 3'd7
   } cmd_type;

   // datapath operations selected by a control word
   typedef enum logic [3:0] {
      OP_NONE,
      OP_PUSH,
      OP_FIND,
      OP_POP,
      OP_GIVE_START,
      OP_GIVE,
      OP_GRANT,
      OP_CHECK,
      OP_WAIT,
      OP_ACQUIRE,
      OP_READ,
      OP_EMIT
   } op_type;

   // branch conditions
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_GIVE_STOP,
      COND_SLOT_FREE
   } cond_type;

   typedef logic [3:0] step_type;

   localparam step_type S_IDLE      = 4'd0;
   localparam step_type S_PUSH      = 4'd1;
   localparam step_type S_POP_FIND  = 4'd2;
   localparam step_type S_POP_TAKE  = 4'd3;
   localparam step_type S_GIVE_FIND = 4'd4;
   localparam step_type S_GIVE_LOOP = 4'd5;
   localparam step_type S_GRANT     = 4'd6;
   localparam step_type S_GRANT_CHK = 4'd7;
   localparam step_type S_WAIT      = 4'd8;
   localparam step_type S_ACQUIRE   = 4'd9;
   localparam step_type S_READ      = 4'd10;
   localparam step_type S_BAD       = 4'd11;
   localparam step_type S_FINISH    = 4'd12;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jmp;    // taken when cond holds
      step_type nxt;    // taken otherwise
      logic     disp;   // branch through the command dispatch table
   } uword_type;

   function automatic uword_type urom(input step_type s);
      uword_type w;
      w = '{OP_NONE, COND_ALWAYS, S_IDLE, S_IDLE, 1'b0};
      case (s)
         S_IDLE:      w = '{OP_NONE,       COND_ALWAYS,    S_IDLE,      S_IDLE,      1'b1};
         S_PUSH:      w = '{OP_PUSH,       COND_ALWAYS,    S_FINISH,    S_FINISH,    1'b0};
         S_POP_FIND:  w = '{OP_FIND,       COND_ALWAYS,    S_POP_TAKE,  S_POP_TAKE,  1'b0};
         S_POP_TAKE:  w = '{OP_POP,        COND_ALWAYS,    S_FINISH,    S_FINISH,    1'b0};
         S_GIVE_FIND: w = '{OP_GIVE_START, COND_ALWAYS,    S_GIVE_LOOP, S_GIVE_LOOP, 1'b0};
         S_GIVE_LOOP: w = '{OP_GIVE,       COND_GIVE_STOP, S_FINISH,    S_GIVE_LOOP, 1'b0};
         S_GRANT:     w = '{OP_GRANT,      COND_ALWAYS,    S_GRANT_CHK, S_GRANT_CHK, 1'b0};
         S_GRANT_CHK: w = '{OP_CHECK,      COND_ALWAYS,    S_FINISH,    S_FINISH,    1'b0};
         S_WAIT:      w = '{OP_WAIT,       COND_ALWAYS,    S_FINISH,    S_FINISH,    1'b0};
         S_ACQUIRE:   w = '{OP_ACQUIRE,    COND_ALWAYS,    S_FINISH,    S_FINISH,    1'b0};
         S_READ:      w = '{OP_READ,       COND_ALWAYS,    S_FINISH,    S_FINISH,    1'b0};
         S_BAD:       w = '{OP_NONE,       COND_ALWAYS,    S_FINISH,    S_FINISH,    1'b0};
         S_FINISH:    w = '{OP_EMIT,       COND_SLOT_FREE, S_IDLE,      S_FINISH,    1'b0};
         default:     w = '{OP_NONE,       COND_ALWAYS,    S_IDLE,      S_IDLE,      1'b0};
      endcase
      return w;
   endfunction

   // entry step of each command's program
   function automatic step_type dispatch(input cmd_type c);
      step_type s;
      case (c)
         CMD_PUSH:    s = S_PUSH;
         CMD_POP:     s = S_POP_FIND;
         CMD_GIVE:    s = S_GIVE_FIND;
         CMD_GRANT:   s = S_GRANT;
         CMD_WAIT:    s = S_WAIT;
         CMD_ACQUIRE: s = S_ACQUIRE;
         CMD_READ:    s = S_READ;
         default:     s = S_BAD;
      endcase
      return s;
   endfunction

   // one-hot of the highest set bit (zero when v is zero)
   function automatic logic [MASK_W-1:0] highest(input logic [MASK_W-1:0] v);
      logic [MASK_W-1:0] s;
      s = v;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      s = s | (s >> 16);
      s = s | (s >> 32);
      return s & ~(s >> 1);
   endfunction

   // index of a one-hot word
   function automatic logic [5:0] encode(input logic [MASK_W-1:0] oh);
      logic [5:0] r;
      r = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (oh[i]) r = r | 6'(i);
      end
      return r;
   endfunction

endpackage

// File: design/processor_mask_ownership_unit.sv
// Steps: push, wait, acquire, read, unknown: own step, FINISH; pop: POP_FIND,
//   POP_TAKE, FINISH; grant: GRANT, GRANT_CHK, FINISH; give: GIVE_FIND,
//   GIVE_LOOP (one bit per cycle until the count is used up or nothing is left
//   to take), FINISH, which waits for a free result slot. One request in flight;
//   the next is taken once the result is loaded, even while it waits in rsp.
// Reset: synchronous, clears all masks, drops rsp_valid, permanent CPU = none.
// ----------------------------------------------------------------------------
// processor_mask_ownership_unit
// Owned/received CPU and GPU masks plus a pending-task mask, driven by a
// small microcoded sequencer over a plain mask datapath.
// ----------------------------------------------------------------------------
module processor_mask_ownership_unit (
   input  logic               clock,
   input  logic               reset,
   // configuration: permanent CPU
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [6:0]  csr_pinned_cpu,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic               req_proc_type,
   input  logic [5:0]         req_proc_index,
   input  logic [6:0]         req_give_count,
   input  logic [63:0]        req_mask_in,
   input  logic [5:0]         req_giver_task,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [6:0]  rsp_popped_index,
   output logic               rsp_ok,
   output logic [63:0]        rsp_mask_out,
   output logic               rsp_all_received
);

   // sequencer
   pmou_pkg::step_type  upc_ff, upc_in;
   pmou_pkg::uword_type uw;
   logic                cond_hit;

   // configuration
   logic [6:0] perm_ff, perm_in;

   // architectural state
   logic [pmou_pkg::MASK_W-1:0] cpu_owned_ff, cpu_owned_in;
   logic [pmou_pkg::MASK_W-1:0] gpu_owned_ff, gpu_owned_in;
   logic [pmou_pkg::MASK_W-1:0] cpu_rx_ff, cpu_rx_in;
   logic [pmou_pkg::MASK_W-1:0] gpu_rx_ff, gpu_rx_in;
   logic [pmou_pkg::MASK_W-1:0] pend_ff, pend_in;

   // latched request
   logic                        gpu_ff, gpu_in;
   logic [5:0]                  idx_ff, idx_in;
   logic [6:0]                  cnt_ff, cnt_in;
   logic [pmou_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic [5:0]                  giver_ff, giver_in;

   // working result and found bit
   logic [pmou_pkg::MASK_W-1:0] oh_ff, oh_in;
   logic signed [6:0]           res_pop_ff, res_pop_in;
   logic                        res_ok_ff, res_ok_in;
   logic [pmou_pkg::MASK_W-1:0] res_mask_ff, res_mask_in;
   logic                        res_all_ff, res_all_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [6:0]           rsp_pop_ff, rsp_pop_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [pmou_pkg::MASK_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic                        rsp_all_ff, rsp_all_in;

   // datapath helpers
   logic [pmou_pkg::MASK_W-1:0] owned_sel;   // owned mask of the latched processor kind
   logic [pmou_pkg::MASK_W-1:0] skip_vec;    // permanent CPU bit, CPU requests only
   logic [pmou_pkg::MASK_W-1:0] cand;        // bits a pop may take
   logic [pmou_pkg::MASK_W-1:0] owned_new;
   logic                        give_stop;
   logic                        slot_free;
   logic                        req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = (upc_ff == pmou_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign uw        = pmou_pkg::urom(upc_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   // give ends when the count is used up or nothing is left to take
   assign give_stop = (cnt_ff == 7'd0) || (oh_ff == '0);

   assign owned_sel = gpu_ff ? gpu_owned_ff : cpu_owned_ff;
   assign skip_vec  = (!gpu_ff && !perm_ff[6]) ? (64'd1 << perm_ff[5:0]) : '0;
   assign cand      = owned_sel & pmou_pkg::PROC_MASK & ~skip_vec;

   always_comb begin
      case (uw.cond)
         pmou_pkg::COND_ALWAYS:    cond_hit = 1'b1;
         pmou_pkg::COND_GIVE_STOP: cond_hit = give_stop;
         pmou_pkg::COND_SLOT_FREE: cond_hit = slot_free;
         default:                  cond_hit = 1'b1;
      endcase
   end

   always_comb begin
      // hold by default
      upc_in       = upc_ff;
      perm_in      = perm_ff;
      cpu_owned_in = cpu_owned_ff;
      gpu_owned_in = gpu_owned_ff;
      cpu_rx_in    = cpu_rx_ff;
      gpu_rx_in    = gpu_rx_ff;
      pend_in      = pend_ff;
      gpu_in       = gpu_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      giver_in     = giver_ff;
      oh_in        = oh_ff;
      res_pop_in   = res_pop_ff;
      res_ok_in    = res_ok_ff;
      res_mask_in  = res_mask_ff;
      res_all_in   = res_all_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pop_in   = rsp_pop_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_all_in   = rsp_all_ff;
      owned_new    = owned_sel;

      if (csr_valid) begin
         perm_in = csr_pinned_cpu;
      end

      // next step
      if (uw.disp) begin
         if (req_fire) upc_in = pmou_pkg::dispatch(pmou_pkg::cmd_type'(req_command));
      end else begin
         upc_in = cond_hit ? uw.jmp : uw.nxt;
      end

      // latch request, preset the fixed result
      if (req_fire) begin
         gpu_in      = req_proc_type;
         idx_in      = req_proc_index;
         cnt_in      = req_give_count;
         mask_in     = req_mask_in;
         giver_in    = req_giver_task;
         res_pop_in  = pmou_pkg::NO_INDEX;
         res_ok_in   = 1'b0;
         res_mask_in = '0;
         res_all_in  = 1'b0;
      end

      case (uw.op)
         pmou_pkg::OP_PUSH: begin
            if (({1'b0, idx_ff} < 7'(pmou_pkg::PROC_COUNT)) && !owned_sel[idx_ff]) begin
               owned_new = owned_sel | (64'd1 << idx_ff);
               res_ok_in = 1'b1;
            end
         end
         pmou_pkg::OP_FIND: begin
            oh_in = pmou_pkg::highest(cand);
         end
         pmou_pkg::OP_POP: begin
            if (oh_ff != '0) begin
               owned_new  = owned_sel & ~oh_ff;
               res_pop_in = signed'({1'b0, pmou_pkg::encode(oh_ff)});
               res_ok_in  = 1'b1;
            end
         end
         pmou_pkg::OP_GIVE_START: begin
            res_ok_in = 1'b1;
            oh_in     = pmou_pkg::highest(cand);
         end
         pmou_pkg::OP_GIVE: begin
            // take last cycle's bit and look for the next one below it
            if (!give_stop) begin
               owned_new   = owned_sel & ~oh_ff;
               res_mask_in = res_mask_ff | oh_ff;
               cnt_in      = cnt_ff - 7'd1;
               oh_in       = pmou_pkg::highest(cand & ~oh_ff);
            end else if (cnt_ff != 7'd0) begin
               res_ok_in = 1'b0;   // ran dry before the count was met
            end
         end
         pmou_pkg::OP_GRANT: begin
            if (gpu_ff) gpu_rx_in = gpu_rx_ff | (mask_ff & pmou_pkg::PROC_MASK);
            else        cpu_rx_in = cpu_rx_ff | (mask_ff & pmou_pkg::PROC_MASK);
            if ({1'b0, giver_ff} < 7'(pmou_pkg::TASK_COUNT)) begin
               pend_in = pend_ff & ~(64'd1 << giver_ff);
            end
            res_ok_in = 1'b1;
         end
         pmou_pkg::OP_CHECK: begin
            res_all_in = (pend_ff == '0);
         end
         pmou_pkg::OP_WAIT: begin
            pend_in   = mask_ff & pmou_pkg::TASK_BITS;
            res_ok_in = 1'b1;
         end
         pmou_pkg::OP_ACQUIRE: begin
            cpu_owned_in = cpu_owned_ff | cpu_rx_ff;
            gpu_owned_in = gpu_owned_ff | gpu_rx_ff;
            cpu_rx_in    = '0;
            gpu_rx_in    = '0;
            pend_in      = '0;
            res_ok_in    = 1'b1;
         end
         pmou_pkg::OP_READ: begin
            res_mask_in = owned_sel;
            res_ok_in   = 1'b1;
         end
         pmou_pkg::OP_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pop_in   = res_pop_ff;
               rsp_ok_in    = res_ok_ff;
               rsp_mask_in  = res_mask_ff;
               rsp_all_in   = res_all_ff;
            end
         end
         default: begin
         end
      endcase

      // write back the selected owned mask for push, pop and give
      if (uw.op == pmou_pkg::OP_PUSH || uw.op == pmou_pkg::OP_POP ||
          uw.op == pmou_pkg::OP_GIVE) begin
         if (gpu_ff) gpu_owned_in = owned_new;
         else        cpu_owned_in = owned_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= pmou_pkg::S_IDLE;
         perm_ff      <= pmou_pkg::PERM_RESET;
         cpu_owned_ff <= '0;
         gpu_owned_ff <= '0;
         cpu_rx_ff    <= '0;
         gpu_rx_ff    <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         perm_ff      <= perm_in;
         cpu_owned_ff <= cpu_owned_in;
         gpu_owned_ff <= gpu_owned_in;
         cpu_rx_ff    <= cpu_rx_in;
         gpu_rx_ff    <= gpu_rx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gpu_ff      <= gpu_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      mask_ff     <= mask_in;
      giver_ff    <= giver_in;
      oh_ff       <= oh_in;
      res_pop_ff  <= res_pop_in;
      res_ok_ff   <= res_ok_in;
      res_mask_ff <= res_mask_in;
      res_all_ff  <= res_all_in;
      rsp_pop_ff  <= rsp_pop_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_all_ff  <= rsp_all_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_index = rsp_pop_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_mask_out     = rsp_mask_ff;
   assign rsp_all_received = rsp_all_ff;

endmodule

// File: design/pmou_checker.sv
// ----------------------------------------------------------------------------
// pmou_checker
// Port-level checks of the processor mask ownership unit, bound to the top.
// ----------------------------------------------------------------------------
`include "processor_mask_ownership_unit_macros.svh"

module pmou_checker (
   input logic              clock,
   input logic              reset,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic signed [6:0] csr_pinned_cpu,
   input logic              req_valid,
   input logic              req_ready,
   input logic [2:0]        req_command,
   input logic              req_proc_type,
   input logic [5:0]        req_proc_index,
   input logic [6:0]        req_give_count,
   input logic [63:0]       req_mask_in,
   input logic [5:0]        req_giver_task,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [6:0] rsp_popped_index,
   input logic              rsp_ok,
   input logic [63:0]       rsp_mask_out,
   input logic              rsp_all_received
);

   // a stalled result holds
   `PMOU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_popped_index) && $stable(rsp_ok) && $stable(rsp_mask_out) && $stable(rsp_all_received), "rsp changed while stalled")

   // one request in flight: ready drops right after an accept
   `PMOU_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // a popped index only comes with success
   `PMOU_ASSERT_NOW(a_pop_ok, clock, reset, rsp_valid && (rsp_popped_index != -7'sd1), rsp_ok, "popped index without ok")

   // all_received only on a successful grant, which never pops
   `PMOU_ASSERT_NOW(a_all_rx, clock, reset, rsp_valid && rsp_all_received, rsp_ok && (rsp_popped_index == -7'sd1), "all_received on wrong result")

endmodule

bind processor_mask_ownership_unit pmou_checker u_pmou_checker (.*);

// File: tb/sv/mask_ownership_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_ownership_checker
// Watches the request, result and permanent-CPU channels of the ownership
// unit. It keeps its own copy of the masks, works out each result and
// compares the results in order.
// ----------------------------------------------------------------------------
module mask_ownership_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic signed [6:0] csr_pinned_cpu,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [2:0]        req_command,
   input  logic              req_proc_type,
   input  logic [5:0]        req_proc_index,
   input  logic [6:0]        req_give_count,
   input  logic [63:0]       req_mask_in,
   input  logic [5:0]        req_giver_task,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic signed [6:0] rsp_popped_index,
   input  logic              rsp_ok,
   input  logic [63:0]       rsp_mask_out,
   input  logic              rsp_all_received,
   output int                fail_count,
   output int                outstanding,
   output int                results_checked
);

   typedef struct packed {
      logic [6:0]  popped_index;
      logic        ok;
      logic [63:0] mask_out;
      logic        all_received;
   } outcome_type;

   logic [63:0] cpu_owned, gpu_owned, cpu_received, gpu_received, pending_tasks;
   logic [6:0]  pinned_cpu;
   outcome_type outcome_q[$];
   int          mismatches = 0;
   int          checked = 0;

   assign fail_count      = mismatches;
   assign results_checked = checked;

   // highest set bit other than skip, -1 if none
   function automatic int highest_free(input logic [63:0] m, input int skip);
      int idx;
      int i;
      idx = -1;
      for (i = 0; i < 64; i++) begin
         if ((m & pmou_pkg::PROC_MASK) >> i & 64'd1 && i != skip) idx = i;
      end
      return idx;
   endfunction

   // applies one request to the mask copy, returns its result
   function automatic outcome_type expected_outcome(
      input logic [2:0]  command,
      input logic        gpu,
      input logic [5:0]  proc_index,
      input logic [6:0]  give_count,
      input logic [63:0] mask_in,
      input logic [5:0]  giver_task
   );
      outcome_type res;
      logic [63:0] owned;
      logic        owned_changed;
      int          skip;
      int          r;
      int          n;
      res = '{pmou_pkg::NO_INDEX, 1'b0, 64'd0, 1'b0};
      owned = gpu ? gpu_owned : cpu_owned;
      owned_changed = 1'b0;
      skip = (gpu || pinned_cpu[6]) ? -1 : int'(pinned_cpu[5:0]);
      case (pmou_pkg::cmd_type'(command))
         pmou_pkg::CMD_PUSH: begin
            if (int'(proc_index) < pmou_pkg::PROC_COUNT && !owned[proc_index]) begin
               owned[proc_index] = 1'b1;
               res.ok = 1'b1;
            end
            owned_changed = 1'b1;
         end
         pmou_pkg::CMD_POP: begin
            r = highest_free(owned, skip);
            if (r >= 0) begin
               owned[r] = 1'b0;
               res.popped_index = 7'(r);
               res.ok = 1'b1;
            end
            owned_changed = 1'b1;
         end
         pmou_pkg::CMD_GIVE: begin
            res.ok = 1'b1;
            for (n = 0; n < int'(give_count) && res.ok; n++) begin
               r = highest_free(owned, skip);
               if (r < 0) begin
                  res.ok = 1'b0;
               end else begin
                  owned[r] = 1'b0;
                  res.mask_out[r] = 1'b1;
               end
            end
            owned_changed = 1'b1;
         end
         pmou_pkg::CMD_GRANT: begin
            if (gpu) gpu_received |= mask_in & pmou_pkg::PROC_MASK;
            else     cpu_received |= mask_in & pmou_pkg::PROC_MASK;
            if (int'(giver_task) < pmou_pkg::TASK_COUNT) pending_tasks[giver_task] = 1'b0;
            res.all_received = (pending_tasks == 64'd0);
            res.ok = 1'b1;
         end
         pmou_pkg::CMD_WAIT: begin
            pending_tasks = mask_in & pmou_pkg::TASK_BITS;
            res.ok = 1'b1;
         end
         pmou_pkg::CMD_ACQUIRE: begin
            cpu_owned |= cpu_received;
            gpu_owned |= gpu_received;
            cpu_received = 64'd0;
            gpu_received = 64'd0;
            pending_tasks = 64'd0;
            res.ok = 1'b1;
         end
         pmou_pkg::CMD_READ: begin
            res.mask_out = owned;
            res.ok = 1'b1;
         end
         default: ;
      endcase
      if (owned_changed) begin
         if (gpu) gpu_owned = owned;
         else     cpu_owned = owned;
      end
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      outcome_type want;
      outcome_type fresh;
      if (reset) begin
         cpu_owned     = 64'd0;
         gpu_owned     = 64'd0;
         cpu_received  = 64'd0;
         gpu_received  = 64'd0;
         pending_tasks = 64'd0;
         pinned_cpu    = pmou_pkg::PERM_RESET;
         outcome_q.delete();
      end else begin
         // result first: it always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: result with no request waiting, expected none actual %h",
                        $time, rsp_mask_out);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               compare_field("popped_index", want.popped_index, $unsigned(rsp_popped_index));
               compare_field("ok", want.ok, rsp_ok);
               compare_field("mask_out", want.mask_out, rsp_mask_out);
               compare_field("all_received", want.all_received, rsp_all_received);
               checked++;
            end
         end
         if (csr_valid && csr_ready) pinned_cpu = csr_pinned_cpu;
         if (req_valid && req_ready) begin
            fresh = expected_outcome(req_command, req_proc_type, req_proc_index,
                                     req_give_count, req_mask_in, req_giver_task);
            outcome_q = {outcome_q, fresh};
         end
      end
      outstanding <= outcome_q.size();
   end

endmodule

// File: tb/sv/tb_processor_mask_ownership_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_processor_mask_ownership_unit
// Drives the ownership unit with a directed opening and three random phases
// at different idle rates and permanent-CPU settings; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_processor_mask_ownership_unit;

   localparam int QUIET_LIMIT     = 4000;  // cycles with no handshake at all
   localparam int HOLD_CYCLES     = 300;   // long result stall, once
   localparam int DRAIN_CYCLES    = 100;   // wait after the final drain
   localparam int ITEMS_PER_PHASE = 660;

   logic              clock;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic signed [6:0] csr_pinned_cpu;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_command;
   logic              req_proc_type;
   logic [5:0]        req_proc_index;
   logic [6:0]        req_give_count;
   logic [63:0]       req_mask_in;
   logic [5:0]        req_giver_task;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [6:0] rsp_popped_index;
   logic              rsp_ok;
   logic [63:0]       rsp_mask_out;
   logic              rsp_all_received;

   int                fail_count;
   int                outstanding;
   int                results_checked;

   int                send_idle_pct = 22;
   int                recv_idle_pct = 61;
   logic              pressure_go;
   int                requests_sent = 0;
   int                csr_writes = 0;
   logic signed [6:0] current_perm = -7'sd1;

   processor_mask_ownership_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_pinned_cpu   (csr_pinned_cpu),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_proc_type    (req_proc_type),
      .req_proc_index   (req_proc_index),
      .req_give_count   (req_give_count),
      .req_mask_in      (req_mask_in),
      .req_giver_task   (req_giver_task),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_index (rsp_popped_index),
      .rsp_ok           (rsp_ok),
      .rsp_mask_out     (rsp_mask_out),
      .rsp_all_received (rsp_all_received)
   );

   mask_ownership_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_pinned_cpu   (csr_pinned_cpu),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_proc_type    (req_proc_type),
      .req_proc_index   (req_proc_index),
      .req_give_count   (req_give_count),
      .req_mask_in      (req_mask_in),
      .req_giver_task   (req_giver_task),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_index (rsp_popped_index),
      .rsp_ok           (rsp_ok),
      .rsp_mask_out     (rsp_mask_out),
      .rsp_all_received (rsp_all_received),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: random back-pressure, plus one long hold-off once the
   // stimulus asks for it. The hold is counted here, not by the sender.
   initial begin : receiver
      logic held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_go && !held) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a correct run never goes this long without a handshake.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // Mostly random bits, with the all-zero, all-one and one-hot corners.
   function automatic logic [63:0] rand_mask();
      case ($urandom_range(7))
         0:       return 64'd0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Give counts stay small most of the time; full-width gives are slow.
   function automatic logic [6:0] pick_count();
      if ($urandom_range(9) == 0) return 7'($urandom_range(64));
      return 7'($urandom_range(6));
   endfunction

   // Push index, leaning on the permanent CPU so that pops run into it.
   function automatic logic [5:0] pick_index(input logic gpu);
      if (!gpu && current_perm >= 0 && $urandom_range(3) == 0)
         return current_perm[5:0];
      return 6'($urandom);
   endfunction

   // One request. A random gap may come first; otherwise valid stays high
   // straight from the previous accept into this request.
   task automatic send_request(input pmou_pkg::cmd_type cmd, input logic gpu,
                               input logic [5:0] index, input logic [6:0] count,
                               input logic [63:0] mask, input logic [5:0] giver);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_proc_type  <= gpu;
      req_proc_index <= index;
      req_give_count <= count;
      req_mask_in    <= mask;
      req_giver_task <= giver;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Shorthand for requests whose unused fields just carry noise.
   task automatic send_simple(input pmou_pkg::cmd_type cmd, input logic gpu,
                              input logic [5:0] index, input logic [6:0] count);
      send_request(cmd, gpu, index, count, rand_mask(), 6'($urandom));
   endtask

   // Stop offering and wait until every result is back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // The register only changes while the unit is idle.
   task automatic write_pinned_cpu(input logic signed [6:0] value);
      drain();
      csr_valid      <= 1'b1;
      csr_pinned_cpu <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      current_perm = value;
      csr_writes++;
   endtask

   // Pushes, pops, gives and reads on one processor kind.
   task automatic churn_round();
      logic gpu;
      int   k;
      gpu = 1'($urandom);
      k = $urandom_range(2, 8);
      repeat (k) begin
         case ($urandom_range(4))
            0, 1:    send_simple(pmou_pkg::CMD_PUSH, gpu, pick_index(gpu), pick_count());
            2:       send_simple(pmou_pkg::CMD_POP, gpu, 6'($urandom), pick_count());
            3:       send_simple(pmou_pkg::CMD_GIVE, gpu, 6'($urandom), pick_count());
            default: send_simple(pmou_pkg::CMD_READ, gpu, 6'($urandom), pick_count());
         endcase
      end
   endtask

   // A full hand-over: wait on a few tasks, a grant from each of them (now
   // and then one from a task nobody waits on), then mostly acquire and read back.
   task automatic grant_round();
      logic [5:0]  givers [4];
      logic [63:0] waiting;
      int          n;
      int          i;
      waiting = 64'd0;
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
         givers[i] = 6'($urandom);
         waiting[givers[i]] = 1'b1;
      end
      send_simple(pmou_pkg::CMD_WAIT, 1'($urandom), 6'($urandom), pick_count());
      // payload of the wait is the pending mask, so resend it properly
      send_request(pmou_pkg::CMD_WAIT, 1'($urandom), 6'($urandom), pick_count(), waiting,
                   6'($urandom));
      for (i = 0; i < n; i++) begin
         if ($urandom_range(4) == 0)
            send_request(pmou_pkg::CMD_GRANT, 1'($urandom), 6'($urandom), pick_count(),
                         rand_mask(), 6'($urandom));
         send_request(pmou_pkg::CMD_GRANT, 1'($urandom), 6'($urandom), pick_count(),
                      rand_mask(), givers[i]);
      end
      // sometimes leave the received masks to pile up over rounds
      if ($urandom_range(5) != 0) begin
         send_simple(pmou_pkg::CMD_ACQUIRE, 1'($urandom), 6'($urandom), pick_count());
         send_simple(pmou_pkg::CMD_READ, 1'b0, 6'($urandom), pick_count());
         send_simple(pmou_pkg::CMD_READ, 1'b1, 6'($urandom), pick_count());
      end
   endtask

   task automatic random_phase(input int count);
      int start;
      int k;
      start = requests_sent;
      while (requests_sent - start < count) begin
         case ($urandom_range(9))
            0, 1, 2, 3: churn_round();
            4, 5, 6, 7: grant_round();
            default: begin
               // noise: any command, any fields, including the unused code
               k = $urandom_range(1, 3);
               repeat (k)
                  send_request(pmou_pkg::cmd_type'($urandom_range(7)), 1'($urandom),
                               6'($urandom), pick_count(), rand_mask(), 6'($urandom));
            end
         endcase
      end
   endtask

   initial begin : stimulus
      reset          <= 1'b1;
      csr_valid      <= 1'b0;
      csr_pinned_cpu <= '0;
      req_valid      <= 1'b0;
      req_command    <= pmou_pkg::CMD_PUSH;
      req_proc_type  <= 1'b0;
      req_proc_index <= '0;
      req_give_count <= '0;
      req_mask_in    <= '0;
      req_giver_task <= '0;
      pressure_go    <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening, no permanent CPU yet.
      send_simple(pmou_pkg::CMD_READ, 1'b0, 6'd5, 7'd0);       // empty read
      send_simple(pmou_pkg::CMD_POP, 1'b0, 6'd0, 7'd0);        // pop on empty mask
      send_simple(pmou_pkg::CMD_GIVE, 1'b1, 6'd0, 7'd3);       // give, nothing there
      send_simple(pmou_pkg::CMD_PUSH, 1'b0, 6'd63, 7'd0);
      send_simple(pmou_pkg::CMD_PUSH, 1'b0, 6'd0, 7'd0);
      send_simple(pmou_pkg::CMD_PUSH, 1'b0, 6'd0, 7'd0);       // already owned
      send_simple(pmou_pkg::CMD_PUSH, 1'b1, 6'd63, 7'd0);
      send_simple(pmou_pkg::CMD_POP, 1'b0, 6'd0, 7'd0);        // takes bit 63
      send_simple(pmou_pkg::CMD_GIVE, 1'b0, 6'd0, 7'd64);      // runs short
      send_request(pmou_pkg::CMD_WAIT, 1'b0, 6'd0, 7'd0, 64'h8000_0000_0000_0001, 6'd0);
      send_request(pmou_pkg::CMD_GRANT, 1'b1, 6'd0, 7'd0, '1, 6'd63); // task 0 still owed
      send_request(pmou_pkg::CMD_GRANT, 1'b0, 6'd0, 7'd0, 64'hA5A5_A5A5_A5A5_A5A5, 6'd0);
      send_simple(pmou_pkg::CMD_ACQUIRE, 1'b1, 6'd0, 7'd0);    // merges both kinds
      send_simple(pmou_pkg::CMD_READ, 1'b1, 6'd0, 7'd0);
      send_simple(pmou_pkg::CMD_GIVE, 1'b1, 6'd0, 7'd64);      // full give
      send_simple(pmou_pkg::CMD_GIVE, 1'b0, 6'd0, 7'd0);       // zero count
      send_request(pmou_pkg::CMD_BAD, 1'b1, 6'd63, 7'd64, '1, 6'd63); // unknown command

      // Permanent CPU at the top index: it must survive gives and pops.
      write_pinned_cpu(7'sd63);
      send_simple(pmou_pkg::CMD_GIVE, 1'b0, 6'd0, 7'd64);
      send_simple(pmou_pkg::CMD_POP, 1'b0, 6'd0, 7'd0);        // only permanent left
      send_simple(pmou_pkg::CMD_PUSH, 1'b0, 6'd10, 7'd0);
      send_simple(pmou_pkg::CMD_GIVE, 1'b0, 6'd0, 7'd2);

      // And at the bottom index.
      write_pinned_cpu(7'sd0);
      send_simple(pmou_pkg::CMD_PUSH, 1'b0, 6'd0, 7'd0);
      send_simple(pmou_pkg::CMD_PUSH, 1'b0, 6'd1, 7'd0);
      send_simple(pmou_pkg::CMD_POP, 1'b0, 6'd0, 7'd0);
      send_simple(pmou_pkg::CMD_POP, 1'b0, 6'd0, 7'd0);

      // Phase 1: sender idles a little, receiver a lot; no permanent CPU.
      write_pinned_cpu(-7'sd1);
      random_phase(ITEMS_PER_PHASE);

      // Phase 2: the other way round; permanent CPU somewhere in the middle.
      write_pinned_cpu(7'($urandom_range(1, 62)));
      send_idle_pct = 61;
      recv_idle_pct = 22;
      random_phase(ITEMS_PER_PHASE);

      // Phase 3: no idling, and one long result stall so requests back up.
      write_pinned_cpu(7'sd63);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pressure_go <= 1'b1;
      random_phase(ITEMS_PER_PHASE);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests over a directed opening and three random phases,",
               requests_sent);
      $display("%0d results compared, %0d permanent CPU settings, one long result stall.",
               results_checked, csr_writes);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
